// ===== src/sct_pkg.sv =====
// shared types and constants of the sequence completion tracker
package sct_pkg;

	localparam int unsigned SeqW = 32;
	localparam int unsigned TagW = 8;
	localparam int unsigned DataW = 64;
	localparam int unsigned MaxRun = 16;

	typedef enum logic [2:0] {
		REQ_ADD_COMPL = 3'd0,
		REQ_ADD_RES   = 3'd1,
		REQ_ADVANCE   = 3'd2,
		REQ_RESULT    = 3'd3,
		REQ_CLOSE     = 3'd4
	} req_t;

	typedef enum logic [1:0] {
		EV_COMPL    = 2'd0,
		EV_RES_DATA = 2'd1,
		EV_RES_NONE = 2'd2,
		EV_REJECT   = 2'd3
	} event_t;

	// one table entry: number, tag, result-listener bit
	typedef struct packed {
		logic [SeqW-1:0] seq;
		logic [TagW-1:0] tag;
		logic            is_res;
	} entry_t;

	localparam int unsigned EntryW = $bits(entry_t);

	// serial less-than on wrapping numbers
	function automatic logic serial_lt(input logic [SeqW-1:0] a, input logic [SeqW-1:0] b);
		logic [SeqW-1:0] d;
		begin
			d = a - b;
			serial_lt = d[SeqW-1];
		end
	endfunction

endpackage

// ===== src/sct_ram.sv =====
// generic single-port write, single-port read ram with registered read
module sct_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/sequence_completion_tracker_top.sv =====
// Sequence completion tracker: the pending listeners sit in a ram in sorted order,
// one entry per address, and each request walks the table through the ram's single
// read port, which sets all timing. A request is accepted in the idle state and
// decoded in the decide state; an add that is answered at once or an unused request
// type ends there. An add that goes in at position P of N pending entries scans P + 1
// entries, then shifts the N - P later entries up one by one and writes the new entry.
// A result that misses ends after its scan; one that matches at P shifts the later
// entries down and, for a result listener, then hands over its beat. An advance or
// close, for each released entry, tests the front, looks at the next entry (not when
// N is 1), sends the beat and shifts down, and then ends the run. Every beat waits in
// an output register while out_ready is low, which stalls the walk; a new request is
// taken once the previous one is done.
module sequence_completion_tracker_top
	import sct_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [2:0]   req_type,
	input  logic [31:0]  seq_num,
	input  logic [7:0]   listener_tag,
	input  logic [63:0]  result_value,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [7:0]   released_tag,
	output logic [1:0]   event_kind,
	output logic [63:0]  result_data,
	output logic         last_of_run
);

	localparam int unsigned AW = $clog2(TABLE_DEPTH);
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);
	localparam int unsigned RunW = $clog2(MaxRun + 1);

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b00000001,
		ST_DECIDE = 8'b00000010,
		ST_SEEK   = 8'b00000100,
		ST_INS    = 8'b00001000,
		ST_REM    = 8'b00010000,
		ST_REL    = 8'b00100000,
		ST_EMIT   = 8'b01000000,
		ST_WAIT   = 8'b10000000
	} state_t;

	state_t state_q;
	logic [2:0]       req_q;
	logic [SeqW-1:0]  seq_q;
	logic [TagW-1:0]  tag_q;
	logic [DataW-1:0] val_q;
	logic [CW-1:0]    count_q;
	logic [SeqW-1:0]  mark_q;
	logic             closed_q;
	logic [CW-1:0]    idx_q;     // scan / shift position
	logic [CW-1:0]    pos_q;     // found position
	logic             rd_pend_q; // ram read data holds a valid entry
	logic [RunW-1:0]  run_q;     // releases in this run
	logic             more_q;    // after the shift, emit the result beat

	// staged beat, waiting for the output register
	logic [TagW-1:0]  stag_q;
	logic [1:0]       skind_q;
	logic [DataW-1:0] sdata_q;
	logic             slast_q;

	// output register
	logic             ov_q;
	logic [TagW-1:0]  otag_q;
	logic [1:0]       okind_q;
	logic [DataW-1:0] odata_q;
	logic             olast_q;

	// ram port signals
	logic              we;
	logic [AW-1:0]     waddr;
	entry_t            wdata;
	logic [AW-1:0]     raddr;
	entry_t            rdata;
	logic [EntryW-1:0] rdata_raw;

	sct_ram #(.WIDTH(EntryW), .DEPTH(TABLE_DEPTH)) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata_raw)
	);
	assign rdata = entry_t'(rdata_raw);

	assign in_ready     = (state_q == ST_IDLE);
	assign out_valid    = ov_q;
	assign released_tag = otag_q;
	assign event_kind   = okind_q;
	assign result_data  = odata_q;
	assign last_of_run  = olast_q;

	logic out_free;
	assign out_free = !ov_q || out_ready;

	logic is_add;
	assign is_add = (req_q == REQ_ADD_COMPL) || (req_q == REQ_ADD_RES);

	// add answered at once: below the mark, after close, or table full
	logic imm_add;
	assign imm_add = serial_lt(seq_q, mark_q) || closed_q || (count_q == DepthC);

	// a beat enters the output register
	logic out_load;
	assign out_load = out_free
	                  && ((state_q == ST_DECIDE && is_add && imm_add) || state_q == ST_EMIT);

	// ram access decode: reads, shifting writes and the new-entry write per state
	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = '0;
		raddr = idx_q[AW-1:0];
		unique case (state_q)
			ST_INS: begin
				// shift from top down: read idx-1, write idx
				raddr = AW'(idx_q - 1'b1);
				if (rd_pend_q) begin
					we    = 1'b1;
					waddr = AW'(idx_q);
					wdata = rdata;
				end else if (idx_q == pos_q) begin
					we    = 1'b1;
					waddr = AW'(pos_q);
					wdata = '{seq: seq_q, tag: tag_q, is_res: (req_q == REQ_ADD_RES)};
				end
			end
			ST_REM: begin
				// shift down: read idx+1, write idx; front entry read once done
				raddr = ((idx_q + 1'b1) < count_q) ? AW'(idx_q + 1'b1) : '0;
				if (rd_pend_q) begin
					we    = 1'b1;
					waddr = AW'(idx_q);
					wdata = rdata;
				end
			end
			ST_SEEK: begin
				// look one entry ahead of the one being examined
				raddr = AW'(idx_q + 1'b1);
			end
			ST_WAIT: begin
				// entry behind the front
				raddr = AW'(1);
			end
			ST_IDLE, ST_DECIDE, ST_REL, ST_EMIT: begin
				raddr = AW'(idx_q);
			end
			default: begin
				raddr = '0;
			end
		endcase
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			mark_q    <= '0;
			closed_q  <= 1'b0;
			idx_q     <= '0;
			pos_q     <= '0;
			rd_pend_q <= 1'b0;
			run_q     <= '0;
			more_q    <= 1'b0;
			ov_q      <= 1'b0;
			olast_q   <= 1'b0;
		end else begin
			if (out_load) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						req_q   <= req_type;
						seq_q   <= seq_num;
						tag_q   <= listener_tag;
						val_q   <= result_value;
						idx_q   <= '0;
						run_q   <= '0;
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					rd_pend_q <= 1'b0;
					if (is_add) begin
						if (imm_add) begin
							if (out_free) begin
								otag_q  <= tag_q;
								odata_q <= '0;
								olast_q <= 1'b1;
								if (count_q == DepthC && !serial_lt(seq_q, mark_q) && !closed_q) begin
									okind_q <= EV_REJECT;
								end else begin
									okind_q <= (req_q == REQ_ADD_RES) ? EV_RES_NONE : EV_COMPL;
								end
								state_q <= ST_IDLE;
							end
						end else begin
							idx_q     <= '0;
							rd_pend_q <= (count_q != '0);
							state_q   <= ST_SEEK;
						end
					end else if (req_q == REQ_RESULT) begin
						idx_q     <= '0;
						rd_pend_q <= (count_q != '0);
						state_q   <= ST_SEEK;
					end else if (req_q == REQ_ADVANCE || req_q == REQ_CLOSE) begin
						if (req_q == REQ_ADVANCE) begin
							mark_q <= seq_q;
						end else begin
							closed_q <= 1'b1;
						end
						idx_q     <= '0;
						rd_pend_q <= (count_q != '0);
						state_q   <= ST_REL;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_SEEK: begin
					// rdata holds entry idx when rd_pend_q
					if (!rd_pend_q || !serial_lt(rdata.seq, seq_q)) begin
						pos_q <= idx_q;
						if (is_add) begin
							idx_q     <= count_q;
							rd_pend_q <= 1'b0;
							state_q   <= ST_INS;
						end else if (rd_pend_q && rdata.seq == seq_q) begin
							if (rdata.is_res) begin
								stag_q  <= rdata.tag;
								skind_q <= EV_RES_DATA;
								sdata_q <= val_q;
								slast_q <= 1'b1;
								more_q  <= 1'b1;
							end else begin
								more_q <= 1'b0;
							end
							rd_pend_q <= 1'b0;
							state_q   <= ST_REM;
						end else begin
							rd_pend_q <= 1'b0;
							state_q   <= ST_IDLE;
						end
					end else begin
						idx_q     <= idx_q + 1'b1;
						rd_pend_q <= ((idx_q + 1'b1) < count_q);
					end
				end
				ST_INS: begin
					if (rd_pend_q) begin
						// entry idx-1 moved to idx
						rd_pend_q <= 1'b0;
						idx_q     <= idx_q - 1'b1;
					end else if (idx_q == pos_q) begin
						count_q <= count_q + 1'b1;
						state_q <= ST_IDLE;
					end else begin
						rd_pend_q <= 1'b1;
					end
				end
				ST_REM: begin
					if (rd_pend_q) begin
						rd_pend_q <= 1'b0;
						idx_q     <= idx_q + 1'b1;
					end else if ((idx_q + 1'b1) < count_q) begin
						rd_pend_q <= 1'b1;
					end else begin
						count_q <= count_q - 1'b1;
						idx_q   <= '0;
						if (req_q == REQ_RESULT) begin
							state_q <= more_q ? ST_EMIT : ST_IDLE;
							more_q  <= 1'b0;
						end else begin
							// continue releasing from the front
							rd_pend_q <= ((count_q - 1'b1) != '0);
							state_q   <= ST_REL;
						end
					end
				end
				ST_REL: begin
					// rdata is the front entry when rd_pend_q
					if (rd_pend_q && run_q != RunW'(MaxRun)
					    && (req_q == REQ_CLOSE || !serial_lt(mark_q, rdata.seq))) begin
						stag_q    <= rdata.tag;
						skind_q   <= rdata.is_res ? EV_RES_NONE : EV_COMPL;
						sdata_q   <= '0;
						run_q     <= run_q + 1'b1;
						rd_pend_q <= 1'b0;
						state_q   <= ST_WAIT;
					end else begin
						rd_pend_q <= 1'b0;
						if (run_q != '0) begin
							// close the run: last beat flagged on final emit
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_WAIT: begin
					// look at next entry to see whether this release is the last one
					if (count_q > CW'(1)) begin
						if (!rd_pend_q) begin
							idx_q     <= CW'(1);
							rd_pend_q <= 1'b1;
						end else begin
							slast_q <= (run_q == RunW'(MaxRun))
							        || !(req_q == REQ_CLOSE || !serial_lt(mark_q, rdata.seq));
							rd_pend_q <= 1'b0;
							idx_q     <= '0;
							state_q   <= ST_EMIT;
						end
					end else begin
						slast_q <= 1'b1;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						otag_q  <= stag_q;
						okind_q <= skind_q;
						odata_q <= sdata_q;
						olast_q <= slast_q;
						if (req_q == REQ_RESULT) begin
							state_q <= ST_IDLE;
						end else begin
							// drop the released front entry
							idx_q     <= '0;
							rd_pend_q <= 1'b0;
							state_q   <= ST_REM;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// the table never holds more than its depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DepthC) else $error("pending count above table depth");

	// a new request is only taken while no release is in flight
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (state_q == ST_IDLE)) else $error("ready outside idle");

	// a beat shown and not taken stays valid and holds its tag and kind
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(released_tag) && $stable(event_kind)))
		else $error("output beat changed while stalled");

	// the mark only moves on an advance
	a_mark: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(mark_q) |-> $past(state_q == ST_DECIDE && req_q == REQ_ADVANCE))
		else $error("mark changed outside advance");

endmodule

// ===== verif/testbench.sv =====
// testbench for the sequence completion tracker: scoreboard with its own table model
`timescale 1ns / 1ps

// expected notifications, worked out from a private copy of the listener table
class release_board;
	logic [31:0] id_q[$];
	logic [7:0] tag_q[$];
	bit res_q[$];
	logic [31:0] mark;
	bit closed;
	logic [7:0] exp_tag[$];
	logic [1:0] exp_kind[$];
	logic [63:0] exp_data[$];
	bit exp_last[$];
	int errors;

	function new();
		mark = '0;
		closed = 0;
		errors = 0;
	endfunction

	function bit seq_below(logic [31:0] a, logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return d[31];
	endfunction

	function void push_event(logic [7:0] t, logic [1:0] k, logic [63:0] v);
		exp_tag.push_back(t);
		exp_kind.push_back(k);
		exp_data.push_back(v);
		exp_last.push_back(1'b0);
	endfunction

	function int pending();
		return exp_tag.size();
	endfunction

	function int table_size();
		return id_q.size();
	endfunction

	// drop the front entry of the table copy
	function void drop_head();
		id_q.delete(0);
		tag_q.delete(0);
		res_q.delete(0);
	endfunction

	// note an accepted request beat and queue its notifications
	function void note_request(logic [2:0] rq, logic [31:0] sq, logic [7:0] tg, logic [63:0] v);
		int before_n;
		int pos;
		sct_pkg::event_t held;
		before_n = exp_tag.size();
		case (rq)
			sct_pkg::REQ_ADD_COMPL, sct_pkg::REQ_ADD_RES: begin
				if (seq_below(sq, mark) || closed) begin
					push_event(tg, (rq == sct_pkg::REQ_ADD_RES) ? sct_pkg::EV_RES_NONE
						: sct_pkg::EV_COMPL, '0);
				end else if (id_q.size() >= 16) begin
					push_event(tg, sct_pkg::EV_REJECT, '0);
				end else begin
					pos = 0;
					while (pos < id_q.size() && seq_below(id_q[pos], sq)) pos++;
					id_q.insert(pos, sq);
					tag_q.insert(pos, tg);
					res_q.insert(pos, rq == sct_pkg::REQ_ADD_RES);
				end
			end
			sct_pkg::REQ_ADVANCE: begin
				mark = sq;
				while (exp_tag.size() - before_n < 16 && id_q.size() > 0
						&& !seq_below(mark, id_q[0])) begin
					held = res_q[0] ? sct_pkg::EV_RES_NONE : sct_pkg::EV_COMPL;
					push_event(tag_q[0], held, '0);
					drop_head();
				end
			end
			sct_pkg::REQ_RESULT: begin
				pos = 0;
				while (pos < id_q.size() && seq_below(id_q[pos], sq)) pos++;
				if (pos < id_q.size() && id_q[pos] == sq) begin
					if (res_q[pos]) push_event(tag_q[pos], sct_pkg::EV_RES_DATA, v);
					id_q.delete(pos);
					tag_q.delete(pos);
					res_q.delete(pos);
				end
			end
			sct_pkg::REQ_CLOSE: begin
				closed = 1;
				while (exp_tag.size() - before_n < 16 && id_q.size() > 0) begin
					held = res_q[0] ? sct_pkg::EV_RES_NONE : sct_pkg::EV_COMPL;
					push_event(tag_q[0], held, '0);
					drop_head();
				end
			end
			default: ;
		endcase
		if (exp_tag.size() > before_n) exp_last[exp_last.size() - 1] = 1'b1;
	endfunction

	// compare one notification beat with the oldest expectation
	function void check_release(logic [7:0] t, logic [1:0] k, logic [63:0] v, logic l);
		logic [7:0] et;
		logic [1:0] ek;
		logic [63:0] ev;
		bit el;
		if (exp_tag.size() == 0) begin
			errors++;
			if (errors <= 10) $display("unexpected beat tag=%0h kind=%0d", t, k);
			return;
		end
		et = exp_tag[0];
		ek = exp_kind[0];
		ev = exp_data[0];
		el = exp_last[0];
		exp_tag.delete(0);
		exp_kind.delete(0);
		exp_data.delete(0);
		exp_last.delete(0);
		if (t !== et || k !== ek || v !== ev || l !== el) begin
			errors++;
			if (errors <= 10)
				$display("mismatch exp tag=%0h kind=%0d data=%0h last=%0b got %0h %0d %0h %0b",
					et, ek, ev, el, t, k, v, l);
		end
	endfunction
endclass

module testbench;
	import sct_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [2:0] req_type = '0;
	logic [31:0] seq_num = '0;
	logic [7:0] listener_tag = '0;
	logic [63:0] result_value = '0;
	logic out_valid;
	logic out_ready = 0;
	logic [7:0] released_tag;
	logic [1:0] event_kind;
	logic [63:0] result_data;
	logic last_of_run;

	release_board board;
	int cycle_count = 0;
	logic [31:0] base_seq = '0;

	sequence_completion_tracker_top #(.TABLE_DEPTH(16)) DUT (.*);

	always #5 clk = ~clk;

	// random gap: mostly short, now and then long
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// receiver side: check on rising edge, vary ready on falling edge
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_release(released_tag, event_kind, result_data, last_of_run);
	end

	initial begin : receiver_stall
		int g;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			out_ready <= 1;
			g = gap_len();
			repeat ($urandom_range(1, 8)) @(negedge clk);
			if (g > 0) begin
				out_ready <= 0;
				repeat (g) @(negedge clk);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 400000) begin
			$display("FAIL");
			$finish;
		end
	end

	// hand one request beat to the block and wait for acceptance; valid stays up
	task automatic send_request(logic [2:0] rq, logic [31:0] sq, logic [7:0] tg, logic [63:0] v);
		in_valid <= 1;
		req_type <= rq;
		seq_num <= sq;
		listener_tag <= tg;
		result_value <= v;
		do @(posedge clk); while (!in_ready);
		board.note_request(rq, sq, tg, v);
		@(negedge clk);
	endtask

	task automatic idle_gap();
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(negedge clk);
		end
	endtask

	task automatic drain_all();
		in_valid <= 0;
		while (board.pending() > 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	initial begin : stimulus
		int i;
		int r;
		logic [31:0] s;
		board = new();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: fill, overflow, match, miss, wrap, advance, close
		for (i = 0; i < 16; i++)
			send_request((i % 2) ? REQ_ADD_RES : REQ_ADD_COMPL, 32'(100 - i * 5), 8'(i), '0);
		send_request(REQ_ADD_COMPL, 32'd200, 8'hff, '0);
		send_request(REQ_RESULT, 32'd95, 8'h0, 64'hffff_ffff_ffff_ffff);
		send_request(REQ_RESULT, 32'd90, 8'h0, 64'h1234);
		send_request(REQ_RESULT, 32'd91, 8'h0, 64'h1);
		send_request(3'd7, 32'hffff_ffff, 8'hff, 64'hffff_ffff_ffff_ffff);
		send_request(3'd5, 32'h0, 8'h0, 64'h0);
		send_request(REQ_ADVANCE, 32'd60, 8'h0, '0);
		send_request(REQ_ADD_RES, 32'd10, 8'h55, '0);
		send_request(REQ_ADD_COMPL, 32'h8000_0050, 8'haa, '0);
		send_request(REQ_ADVANCE, 32'hffff_fff0, 8'h0, '0);
		drain_all();
		send_request(REQ_CLOSE, 32'h0, 8'h0, '0);
		send_request(REQ_ADD_RES, 32'hffff_ffff, 8'h33, '0);
		send_request(3'd6, 32'h0, 8'h0, '0);
		drain_all();

		// random: mostly windowed numbers near the mark, some noise
		base_seq = $urandom();
		for (i = 0; i < 200; i++) begin
			if (i == 100) drain_all();
			r = $urandom_range(0, 99);
			s = base_seq + $urandom_range(0, 40);
			if (r < 3) s = $urandom();
			if (r < 40)
				send_request(REQ_ADD_COMPL, s, 8'($urandom()), '0);
			else if (r < 70)
				send_request(REQ_ADD_RES, s, 8'($urandom()), '0);
			else if (r < 82)
				send_request(REQ_RESULT, s, 8'($urandom()), {$urandom(), $urandom()});
			else if (r < 92) begin
				send_request(REQ_ADVANCE, base_seq + $urandom_range(0, 25), '0, '0);
				base_seq = base_seq + $urandom_range(0, 20);
			end else if (r < 94)
				send_request(REQ_CLOSE, $urandom(), 8'($urandom()), '0);
			else
				send_request(3'($urandom_range(5, 7)), $urandom(), 8'($urandom()),
					{$urandom(), $urandom()});
			if (r == 93) begin
				drain_all();
			end
			idle_gap();
		end
		in_valid <= 0;
		while (board.pending() > 0) @(negedge clk);
		repeat (100) @(negedge clk);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
src/sct_pkg.sv
src/sct_ram.sv
src/sequence_completion_tracker_top.sv
verif/testbench.sv
